// ----- design/lap_pkg.sv -----
package lap_pkg;

    // line buffer geometry
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;

    // configuration port
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int WIDTH_REG_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd512;
    localparam logic [ROW_W-1:0]       HEIGHT_RESET = 16'd512;
    localparam logic [ROW_W-1:0]       HEIGHT_MIN   = 16'd3;

    // input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef logic [7:0] pixel_t;

    typedef enum logic [1:0] {
        KERNEL_CROSS     = 2'd0,
        KERNEL_CROSS_NEG = 2'd1,
        KERNEL_BOX       = 2'd2,
        KERNEL_BOX_NEG   = 2'd3
    } kernel_t;

    // one result item
    typedef struct packed {
        pixel_t pixel;
        logic   last;
    } lap_result_t;

    // results produced by one accepted item
    typedef struct packed {
        logic [1:0]  count;
        lap_result_t first;
        lap_result_t second;
    } lap_push_t;

    // line buffer access for one cycle
    typedef struct packed {
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
        pixel_t           older_wd;
        pixel_t           newer_wd;
        logic [COL_W-1:0] rd_addr;
    } lap_mem_req_t;

    // 3x3 kernel sum, low 8 bits; taps indexed row * 3 + column
    function automatic pixel_t lap_filter(kernel_t sel, logic [8:0][7:0] taps);
        logic [9:0]  side_sum;
        logic [10:0] ring;
        pixel_t      centre;
        pixel_t      v;
        side_sum = {2'b00, taps[1]} + {2'b00, taps[3]} + {2'b00, taps[5]} + {2'b00, taps[7]};
        ring     = {1'b0, side_sum} + {3'b000, taps[0]} + {3'b000, taps[2]}
                 + {3'b000, taps[6]} + {3'b000, taps[8]};
        centre   = taps[4];
        case (sel)
            KERNEL_CROSS:     v = side_sum[7:0] - {centre[5:0], 2'b00};
            KERNEL_CROSS_NEG: v = {centre[5:0], 2'b00} - side_sum[7:0];
            KERNEL_BOX:       v = ring[7:0] - {centre[4:0], 3'b000};
            KERNEL_BOX_NEG:   v = {centre[4:0], 3'b000} - ring[7:0];
            default:          v = centre;
        endcase
        return v;
    endfunction

endpackage

// ----- design/lap_line_buffers.sv -----
module lap_line_buffers (
    input  logic                  clk,
    input  lap_pkg::lap_mem_req_t req,
    output lap_pkg::pixel_t       older_rd,
    output lap_pkg::pixel_t       newer_rd
);
    import lap_pkg::*;

    pixel_t older_mem [MAX_WIDTH];
    pixel_t newer_mem [MAX_WIDTH];
    pixel_t older_rd_reg;
    pixel_t newer_rd_reg;

    // column write, registered read of the next column
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            older_mem[req.wr_addr] <= req.older_wd;
            newer_mem[req.wr_addr] <= req.newer_wd;
        end
        older_rd_reg <= older_mem[req.rd_addr];
        newer_rd_reg <= newer_mem[req.rd_addr];
    end

    assign older_rd = older_rd_reg;
    assign newer_rd = newer_rd_reg;

endmodule

// ----- design/lap_core.sv -----
module lap_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              command,
    input  lap_pkg::pixel_t                   pixel_in,
    input  logic                              cfg_write_en,
    input  logic [lap_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lap_pkg::CFG_W-1:0]         cfg_data,
    input  lap_pkg::pixel_t                   older_rd,
    input  lap_pkg::pixel_t                   newer_rd,
    output lap_pkg::lap_mem_req_t             mem_req,
    output lap_pkg::lap_push_t                push
);
    import lap_pkg::*;

    kernel_t                kernel_reg;
    logic [WIDTH_REG_W-1:0] width_reg;
    logic [ROW_W-1:0]       height_reg;
    logic [COL_W-1:0]       column_count_reg, column_count_next;
    logic [ROW_W-1:0]       row_count_reg, row_count_next;
    logic [COL_W-1:0]       drain_count_reg, drain_count_next;
    logic [5:0][7:0]        window_reg;

    logic [COL_W-1:0]       last_col;
    logic [ROW_W-1:0]       h_eff;
    logic                   frame_full;
    logic                   col_last;
    logic                   drain_last;
    logic                   pixel_go;
    logic                   drain_go;
    logic                   restart;
    logic                   interior;
    logic [8:0][7:0]        taps;
    pixel_t                 filtered;

    // effective frame size
    always_comb
    begin
        if (width_reg < WIDTH_REG_W'(3))
            last_col = COL_W'(2);
        else if (int'(width_reg) > MAX_WIDTH)
            last_col = COL_W'(MAX_WIDTH - 1);
        else
            last_col = COL_W'(width_reg - WIDTH_REG_W'(1));
        h_eff = (height_reg < HEIGHT_MIN) ? HEIGHT_MIN : height_reg;
    end

    assign frame_full = (row_count_reg >= h_eff);
    assign col_last   = (column_count_reg == last_col);
    assign drain_last = (drain_count_reg == last_col);
    assign pixel_go   = accept && (command == CMD_PIXEL) && !frame_full;
    assign drain_go   = accept && (command == CMD_DRAIN) && frame_full;
    assign restart    = cfg_write_en && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

    // counter update
    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        drain_count_next  = drain_count_reg;
        if (restart)
        begin
            column_count_next = '0;
            row_count_next    = '0;
            drain_count_next  = '0;
        end
        else if (drain_go)
        begin
            if (drain_last)
            begin
                column_count_next = '0;
                row_count_next    = '0;
                drain_count_next  = '0;
            end
            else
                drain_count_next = drain_count_reg + COL_W'(1);
        end
        else if (pixel_go)
        begin
            if (col_last)
            begin
                column_count_next = '0;
                row_count_next    = row_count_reg + ROW_W'(1);
            end
            else
                column_count_next = column_count_reg + COL_W'(1);
        end
    end

    // window taps: column c-2 from the window, c-1 from the window, c from buffers and pixel_in
    always_comb
    begin
        taps[0] = window_reg[0];
        taps[1] = window_reg[3];
        taps[2] = older_rd;
        taps[3] = window_reg[1];
        taps[4] = window_reg[4];
        taps[5] = newer_rd;
        taps[6] = window_reg[2];
        taps[7] = window_reg[5];
        taps[8] = pixel_in;
    end

    assign filtered = lap_filter(kernel_reg, taps);
    assign interior = (row_count_reg >= ROW_W'(2)) && (column_count_reg >= COL_W'(2));

    // results of this item
    always_comb
    begin
        push.count        = 2'd0;
        push.first.pixel  = interior ? filtered : window_reg[4];
        push.first.last   = 1'b0;
        push.second.pixel = newer_rd;
        push.second.last  = 1'b0;
        if (drain_go)
        begin
            push.count       = 2'd1;
            push.first.pixel = newer_rd;
            push.first.last  = drain_last;
        end
        else if (pixel_go && (row_count_reg != '0) && (column_count_reg != '0))
            push.count = col_last ? 2'd2 : 2'd1;
    end

    // line buffer access, read address runs one item ahead
    always_comb
    begin
        mem_req.wr_en    = pixel_go;
        mem_req.wr_addr  = column_count_reg;
        mem_req.older_wd = newer_rd;
        mem_req.newer_wd = pixel_in;
        mem_req.rd_addr  = (row_count_next >= h_eff) ? drain_count_next : column_count_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= KERNEL_CROSS;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_KERNEL: kernel_reg <= kernel_t'(cfg_data[1:0]);
                REG_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[ROW_W-1:0];
                default:    ;
            endcase
        end
    end

    // frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            drain_count_reg  <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            drain_count_reg  <= drain_count_next;
        end
    end

    // sliding window of the two previous columns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= '0;
        else if (pixel_go)
        begin
            window_reg[0] <= window_reg[3];
            window_reg[1] <= window_reg[4];
            window_reg[2] <= window_reg[5];
            window_reg[3] <= older_rd;
            window_reg[4] <= newer_rd;
            window_reg[5] <= pixel_in;
        end
    end

endmodule

// ----- design/lap_out_queue.sv -----
module lap_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  lap_pkg::lap_push_t push,
    input  logic               out_stall,
    output logic               out_valid,
    output lap_pkg::pixel_t    pixel_out,
    output logic               frame_last,
    output logic [2:0]         level
);
    import lap_pkg::*;

    localparam logic [1:0] LAST_SLOT = 2'd3;

    lap_result_t slot_reg [4];
    logic [2:0]  level_reg, level_next;
    logic [1:0]  rd_ptr_reg;
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  wr_ptr_plus;
    logic        pop;

    function automatic logic [1:0] ptr_inc(logic [1:0] p);
        return (p == LAST_SLOT) ? 2'd0 : p + 2'd1;
    endfunction

    assign wr_ptr_plus = ptr_inc(wr_ptr_reg);
    assign pop         = out_valid && !out_stall;
    assign level_next  = level_reg + {1'b0, push.count} - {2'b00, pop};

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= '0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            case (push.count)
                2'd1:    wr_ptr_reg <= wr_ptr_plus;
                2'd2:    wr_ptr_reg <= ptr_inc(wr_ptr_plus);
                default: ;
            endcase
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            slot_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            slot_reg[wr_ptr_plus] <= push.second;
    end

    assign out_valid  = (level_reg != 3'd0);
    assign pixel_out  = slot_reg[rd_ptr_reg].pixel;
    assign frame_last = slot_reg[rd_ptr_reg].last;
    assign level      = level_reg;

endmodule

// ----- design/laplacian_3x3_convolution_unit.sv -----
// channel   handshake                 payload
// input     in_valid / in_stall       command, pixel_in
// output    out_valid / out_stall     pixel_out, frame_last
// config    cfg_write_en              cfg_index, cfg_data
//
// one pixel per cycle while in_stall is low; a result item is written into the output queue as its pixel is accepted.
// the pixel closing a row yields two items and the next pixel (first column) yields none,
// so the four-entry output queue absorbs the pair and rows follow back to back.
// reset clears counters, window and queue; line buffers hold no reset value.
// the input stalls while three or more items wait in the output queue.
module laplacian_3x3_convolution_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  lap_pkg::pixel_t               pixel_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output lap_pkg::pixel_t               pixel_out,
    output logic                          frame_last,
    input  logic                          cfg_write_en,
    input  logic [lap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lap_pkg::CFG_W-1:0]     cfg_data
);
    import lap_pkg::*;

    lap_mem_req_t mem_req;
    lap_push_t    push;
    pixel_t       older_rd;
    pixel_t       newer_rd;
    logic [2:0]   level;
    logic         accept;

    // room for the two items a row end can produce
    assign in_stall = (level >= 3'd3);
    assign accept   = in_valid && !in_stall;

    lap_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .command      (command),
        .pixel_in     (pixel_in),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .older_rd     (older_rd),
        .newer_rd     (newer_rd),
        .mem_req      (mem_req),
        .push         (push)
    );

    lap_line_buffers u_lines (
        .clk      (clk),
        .req      (mem_req),
        .older_rd (older_rd),
        .newer_rd (newer_rd)
    );

    lap_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .pixel_out  (pixel_out),
        .frame_last (frame_last),
        .level      (level)
    );

    // results only come from accepted items
    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> accept)
        else $error("result pushed without an accepted item");

    // two results only at a row end, never the frame end
    a_pair_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> !push.first.last)
        else $error("frame end flagged on a row-end pair");

    // queue has room for a pair when one is pushed
    a_pair_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (level <= 3'd2))
        else $error("output queue overflow");

endmodule
